@@ rtl/llga_pkg.sv @@
// ----------------------------------------------------------------------------
// llga_pkg
// Shared sizes, codes and types of the life-like grid automaton.
// ----------------------------------------------------------------------------
package llga_pkg;

	// grid size
	localparam int GRID_WIDTH  = 64;  // columns, 3 .. 64
	localparam int GRID_HEIGHT = 64;  // rows, 3 .. 64

	localparam int ROW_W = $clog2(GRID_HEIGHT);  // row index bits
	localparam int CNT_W = $clog2(GRID_WIDTH);   // column counter bits

	typedef logic [GRID_HEIGHT-1:0] column_t;

	// item kinds
	typedef enum logic [1:0] {
		KIND_TOGGLE = 2'd0,
		KIND_STEP   = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	// register indexes
	localparam logic [1:0] REG_DEATH_LOW = 2'd0;
	localparam logic [1:0] REG_DEATH_UP  = 2'd1;
	localparam logic [1:0] REG_BIRTH     = 2'd2;

	typedef struct packed {
		logic [3:0] death_low;
		logic [3:0] death_up;
		logic [3:0] birth;
	} rule_cfg_t;

	// control shared by every column cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

@@ rtl/llga_cell.sv @@
// ----------------------------------------------------------------------------
// llga_cell
// One column of the grid; hands its column to the next cell on a shift.
// ----------------------------------------------------------------------------
module llga_cell
	import llga_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  column_t    shift_in,
	output column_t    col
);

	column_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctrl.clear) begin
			col_q <= '0;
		end else if (ctrl.shift) begin
			col_q <= shift_in;
		end
	end

	assign col = col_q;

endmodule

@@ rtl/llga_rule.sv @@
// ----------------------------------------------------------------------------
// llga_rule
// Next generation of one interior column from its old column and neighbors.
// ----------------------------------------------------------------------------
module llga_rule
	import llga_pkg::*;
(
	input  column_t   left,
	input  column_t   mid,
	input  column_t   right,
	input  rule_cfg_t cfg,
	output column_t   next_col
);

	always_comb begin
		logic [3:0] count;
		next_col = mid;
		// border rows keep their value
		for (int r = 1; r < GRID_HEIGHT - 1; r++) begin
			count = 4'(left[r-1]) + 4'(mid[r-1]) + 4'(right[r-1])
				+ 4'(left[r]) + 4'(right[r])
				+ 4'(left[r+1]) + 4'(mid[r+1]) + 4'(right[r+1]);
			if (mid[r]) begin
				if (count <= cfg.death_low || count >= cfg.death_up)
					next_col[r] = 1'b0;
			end else if (count == cfg.birth) begin
				next_col[r] = 1'b1;
			end
		end
	end

endmodule

@@ rtl/life_like_grid_automaton_core.sv @@
// ----------------------------------------------------------------------------
// life_like_grid_automaton_core
// Grid of one-bit cells held in a ring of column cells; toggle, step,
// clear and read items, one result beat per item.
// ----------------------------------------------------------------------------
// usage
//   an item (kind, cell_x, cell_y) is taken at a clock edge with start high
//   and busy low. every item gives exactly one result beat: done is high for
//   one cycle with cell_value alongside. the receiver cannot stall, so the
//   beat must be taken in that cycle.
//   toggle, read and step rotate the column ring once around: the grid
//   moves one column per cycle past the head of the ring, where the addressed
//   column is toggled or sampled, or where a new column is built from a
//   three-column window. the result beat comes at the end of the sweep,
//   and busy drops in that same cycle, so a new item may be started at
//   the edge that ends the beat.
//   clear wipes every column at the edge that takes it and gives its beat
//   in the next cycle without raising busy.
//   rule registers are written through cfg_we / cfg_index / cfg_data by the
//   user while the block is idle (not enforced by the block); index 3 is ignored.
//   reset clears the grid, loads the rule defaults (1, 4, 3) and drops
//   busy and done.
// ----------------------------------------------------------------------------
module life_like_grid_automaton_core
	import llga_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// item channel
	input  logic       start,
	output logic       busy,
	input  logic [1:0] kind,
	input  logic [5:0] cell_x,
	input  logic [5:0] cell_y,
	// result channel
	output logic       done,
	output logic       cell_value,
	// rule registers
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_SWEEP = 2'b10
	} state_t;

	state_t     state_q;
	kind_t      kind_q;
	logic [5:0] cell_x_q;
	logic [5:0] cell_y_q;
	logic [CNT_W-1:0] cnt_q;      // column now sitting at the head
	logic       value_q;          // result gathered during the sweep
	logic       value_d;          // result including the head column
	logic       done_q;
	logic       cell_value_q;
	rule_cfg_t  cfg_q;
	column_t    prev_q;           // old column that just left the head

	column_t    cols [GRID_WIDTH];
	column_t    feed;             // column going back in at the tail
	column_t    rule_col;
	column_t    toggle_mask;
	cell_ctrl_t ctrl;

	logic       accept;
	logic       last;
	logic       match;
	logic       inside_y;
	logic       interior;
	logic [ROW_W-1:0] row;

	assign accept   = start && (state_q == ST_IDLE);
	assign last     = (cnt_q == CNT_W'(GRID_WIDTH - 1));
	assign match    = (32'(cell_x_q) == 32'(cnt_q));
	assign inside_y = (32'(cell_y_q) < GRID_HEIGHT);
	assign interior = (cnt_q != '0) && !last;
	assign row      = cell_y_q[ROW_W-1:0];

	// ------------------------------------------------------------------
	// rule registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.death_low <= 4'd1;
			cfg_q.death_up  <= 4'd4;
			cfg_q.birth     <= 4'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEATH_LOW: cfg_q.death_low <= cfg_data;
				REG_DEATH_UP:  cfg_q.death_up  <= cfg_data;
				REG_BIRTH:     cfg_q.birth     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// column ring: cell i takes cell i+1, the tail takes the head's
	// processed column
	// ------------------------------------------------------------------
	assign ctrl.shift = (state_q == ST_SWEEP);
	assign ctrl.clear = accept && (kind_t'(kind) == KIND_CLEAR);

	for (genvar i = 0; i < GRID_WIDTH; i++) begin : g_ring
		if (i == GRID_WIDTH - 1) begin : g_tail
			llga_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.shift_in (feed),
				.col      (cols[i])
			);
		end else begin : g_body
			llga_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.shift_in (cols[i+1]),
				.col      (cols[i])
			);
		end
	end

	// next generation of the head column; cols[1] still holds the old
	// right neighbor for every interior column
	llga_rule u_rule (
		.left     (prev_q),
		.mid      (cols[0]),
		.right    (cols[1]),
		.cfg      (cfg_q),
		.next_col (rule_col)
	);

	always_comb begin
		toggle_mask      = '0;
		toggle_mask[row] = 1'b1;
	end

	// what goes back into the ring for the head column
	always_comb begin
		feed = cols[0];
		case (kind_q)
			KIND_STEP: begin
				if (interior)
					feed = rule_col;
			end
			KIND_TOGGLE: begin
				if (match && inside_y)
					feed = cols[0] ^ toggle_mask;
			end
			default: ;
		endcase
	end

	// result value with the head column taken into account, so the last
	// column of the sweep counts as well
	always_comb begin
		value_d = value_q;
		if (match && inside_y) begin
			// toggle reports the bit after the flip
			if (kind_q == KIND_TOGGLE)
				value_d = ~cols[0][row];
			else if (kind_q == KIND_READ)
				value_d = cols[0][row];
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (kind_t'(kind) == KIND_CLEAR)
							done_q <= 1'b1;
						else
							state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and result value
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind_t'(kind);
			cell_x_q <= cell_x;
			cell_y_q <= cell_y;
			value_q  <= 1'b0;
		end else if (state_q == ST_SWEEP) begin
			value_q <= value_d;
		end
		if (state_q == ST_SWEEP)
			prev_q <= cols[0];
		// clear and step report 0
		if (accept && kind_t'(kind) == KIND_CLEAR)
			cell_value_q <= 1'b0;
		else if (state_q == ST_SWEEP && last)
			cell_value_q <= value_d;
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign cell_value = cell_value_q;

endmodule
